@@ sv/bfc_pkg.sv @@
package bfc_pkg;

  // Fixed field widths of the item channels.
  localparam int SIZE_W      = 41;
  localparam int IN_ADDR_W   = 48;
  localparam int STATUS_W    = 2;

  // Configuration port.
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_ON_RELEASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2        = 1'b1;

  localparam logic                 CFG_MERGE_RESET = 1'b1;
  localparam logic [CFG_DATA_W-1:0] CFG_PAGE_RESET = 5'd12;

  // Request modes.
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_SERVED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd3;

  typedef struct packed {
    logic                 mode;
    logic [SIZE_W-1:0]    block_size;
    logic [IN_ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IN_ADDR_W-1:0] granted_address;
  } out_item_t;

endpackage

@@ sv/best_fit_free_block_cache.sv @@
// Best-fit free block cache. The block keeps a table of TABLE_ENTRIES free
// memory blocks (start address and size) and serves one item at a time. An
// allocate item rounds its size up to whole pages and takes the smallest
// fitting block, lowest address first on a tie, leaving any remainder in the
// same slot; a release item is coalesced with the free blocks that touch it
// on either side, stored as it is, or dropped. Every item gives exactly one
// result item. An item that needs the table passes through a scan that reads
// every entry of the table memory through a registered read, a comparison of
// the last entry read, an update step that writes the memory at most once,
// and the load of the output register, which waits while a held result is
// stalled. Items decided without the table (zero-size requests, releases
// below one page without merging) skip the scan and the update. Input stall
// is high from acceptance until the result has been loaded; a finished result
// waits in the output register while the next item is taken. Valid bits live
// in flip-flops and are cleared at reset, so the table is empty at once and no
// clearing pass is needed. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module best_fit_free_block_cache #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDRESS_BITS  = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bfc_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bfc_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_we_i,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bfc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import bfc_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int AW     = ADDRESS_BITS;
  localparam int NEED_W = SIZE_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_PLAIN = 2'd1,
    OP_MERGE = 2'd2
  } op_e;

  typedef struct packed {
    logic [AW-1:0]     addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Control state.
  state_e                  state_q, state_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic                    out_valid_q, out_valid_d;
  logic                    merge_q;
  logic [CFG_DATA_W-1:0]   page_log2_q;
  logic [CNT_W-1:0]        rd_cnt_q, rd_cnt_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic                    cand_found_q, cand_found_d;
  logic                    hit_found_q, hit_found_d;
  logic                    free_found_q, free_found_d;

  // Request and scan payload.
  op_e                     op_q, op_d;
  logic [AW-1:0]           req_addr_q, req_addr_d;
  logic [SIZE_W-1:0]       req_size_q, req_size_d;
  logic [NEED_W-1:0]       need_q, need_d;
  logic [AW-1:0]           end_q, end_d;
  logic [IDX_W-1:0]        cmp_idx_q, cmp_idx_d;
  logic                    rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0]        cand_idx_q, cand_idx_d;
  logic [AW-1:0]           cand_addr_q, cand_addr_d;
  logic [SIZE_W-1:0]       cand_size_q, cand_size_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic [SIZE_W-1:0]       hit_size_q, hit_size_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;
  logic [STATUS_W-1:0]     res_status_q, res_status_d;
  logic [IN_ADDR_W-1:0]    res_addr_q, res_addr_d;
  out_item_t               out_q, out_d;

  // Table memory: one write and one registered read per cycle.
  entry_t                  mem_q [TABLE_ENTRIES];
  entry_t                  rd_data_q;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  entry_t                  mem_wdata;

  // Request decode at acceptance.
  logic [NEED_W-1:0]       page, page_mask, in_size_ext;
  logic [AW-1:0]           in_addr;

  assign page        = NEED_W'(1) << page_log2_q;
  assign page_mask   = page - NEED_W'(1);
  assign in_size_ext = {1'b0, in_item_i.block_size};
  assign in_addr     = AW'(in_item_i.block_address);

  // Shared comparison unit: judges the entry read in the previous cycle.
  logic [NEED_W-1:0] rsum;
  logic              alloc_take, plain_dup, merge_right, merge_left, free_take;

  assign rsum        = {1'b0, rd_data_q.size} + {1'b0, req_size_q};
  assign alloc_take  = rd_valid_q && ({1'b0, rd_data_q.size} >= need_q) &&
                       (!cand_found_q || (rd_data_q.size < cand_size_q) ||
                        ((rd_data_q.size == cand_size_q) && (rd_data_q.addr < cand_addr_q)));
  assign plain_dup   = rd_valid_q && (rd_data_q.addr == req_addr_q) &&
                       (rd_data_q.size == req_size_q);
  assign merge_right = rd_valid_q && !hit_found_q && (rd_data_q.addr == end_q) &&
                       !rsum[SIZE_W];
  assign merge_left  = rd_valid_q && (rd_data_q.addr < req_addr_q) &&
                       (!cand_found_q || (rd_data_q.addr > cand_addr_q));
  assign free_take   = !rd_valid_q && !free_found_q;

  // Merge decision for the update cycle.
  logic [NEED_W-1:0] m_size_ext, lsum;
  logic [SIZE_W-1:0] m_size, new_size;
  logic [AW-1:0]     new_addr;
  logic              left_ok;
  logic              slot_found;
  logic [IDX_W-1:0]  slot_idx;

  assign m_size_ext = {1'b0, req_size_q} + (hit_found_q ? {1'b0, hit_size_q} : '0);
  assign m_size     = m_size_ext[SIZE_W-1:0];
  assign lsum       = {1'b0, cand_size_q} + {1'b0, m_size};
  assign left_ok    = cand_found_q && ((cand_addr_q + AW'(cand_size_q)) == req_addr_q) &&
                      !lsum[SIZE_W];
  assign new_addr   = left_ok ? cand_addr_q : req_addr_q;
  assign new_size   = left_ok ? lsum[SIZE_W-1:0] : m_size;

  // The new entry goes to the lowest slot that is free once the merged
  // neighbours have been given up.
  always_comb begin
    slot_found = free_found_q;
    slot_idx   = free_idx_q;
    if (hit_found_q && (!slot_found || (hit_idx_q < slot_idx))) begin
      slot_found = 1'b1;
      slot_idx   = hit_idx_q;
    end
    if (left_ok && (!slot_found || (cand_idx_q < slot_idx))) begin
      slot_found = 1'b1;
      slot_idx   = cand_idx_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    out_valid_d  = out_valid_q;
    rd_cnt_d     = rd_cnt_q;
    cmp_vld_d    = cmp_vld_q;
    cand_found_d = cand_found_q;
    hit_found_d  = hit_found_q;
    free_found_d = free_found_q;
    op_d         = op_q;
    req_addr_d   = req_addr_q;
    req_size_d   = req_size_q;
    need_d       = need_q;
    end_d        = end_q;
    cmp_idx_d    = cmp_idx_q;
    rd_valid_d   = rd_valid_q;
    cand_idx_d   = cand_idx_q;
    cand_addr_d  = cand_addr_q;
    cand_size_d  = cand_size_q;
    hit_idx_d    = hit_idx_q;
    hit_size_d   = hit_size_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cand_idx_q;
    mem_wdata    = '{addr: req_addr_q, size: req_size_q};
    mem_raddr    = rd_cnt_q[IDX_W-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_addr_d   = in_addr;
          req_size_d   = in_item_i.block_size;
          need_d       = (in_size_ext + page_mask) & ~page_mask;
          end_d        = in_addr + AW'(in_item_i.block_size);
          rd_cnt_d     = '0;
          cmp_vld_d    = 1'b0;
          cand_found_d = 1'b0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          res_addr_d   = '0;
          state_d      = ST_SCAN;
          if (in_item_i.mode == MODE_ALLOC) begin
            op_d = OP_ALLOC;
            if (in_item_i.block_size == '0) begin
              res_status_d = STATUS_MISS;
              state_d      = ST_RESP;
            end
          end else if (merge_q) begin
            op_d = OP_MERGE;
            if (in_item_i.block_size == '0) begin
              res_status_d = STATUS_DROPPED;
              state_d      = ST_RESP;
            end
          end else begin
            op_d = OP_PLAIN;
            // A zero size is below one page as well.
            if (in_size_ext < page) begin
              res_status_d = STATUS_DROPPED;
              state_d      = ST_RESP;
            end
          end
        end
      end

      ST_SCAN: begin
        if (cmp_vld_q) begin
          if (free_take) begin
            free_found_d = 1'b1;
            free_idx_d   = cmp_idx_q;
          end
          unique case (op_q)
            OP_ALLOC: begin
              if (alloc_take) begin
                cand_found_d = 1'b1;
                cand_idx_d   = cmp_idx_q;
                cand_addr_d  = rd_data_q.addr;
                cand_size_d  = rd_data_q.size;
              end
            end
            OP_PLAIN: begin
              if (plain_dup) begin
                hit_found_d = 1'b1;
              end
            end
            OP_MERGE: begin
              // The first right neighbour is taken out of the left search.
              priority if (merge_right) begin
                hit_found_d = 1'b1;
                hit_idx_d   = cmp_idx_q;
                hit_size_d  = rd_data_q.size;
              end else if (merge_left) begin
                cand_found_d = 1'b1;
                cand_idx_d   = cmp_idx_q;
                cand_addr_d  = rd_data_q.addr;
                cand_size_d  = rd_data_q.size;
              end
            end
            default: begin
            end
          endcase
        end
        if (rd_cnt_q != CNT_W'(TABLE_ENTRIES)) begin
          mem_re     = 1'b1;
          rd_cnt_d   = rd_cnt_q + CNT_W'(1);
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = rd_cnt_q[IDX_W-1:0];
          rd_valid_d = valid_q[rd_cnt_q[IDX_W-1:0]];
        end else begin
          cmp_vld_d = 1'b0;
          state_d   = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        state_d = ST_RESP;
        unique case (op_q)
          OP_ALLOC: begin
            if (cand_found_q) begin
              res_status_d = STATUS_SERVED;
              res_addr_d   = IN_ADDR_W'(cand_addr_q);
              if ({1'b0, cand_size_q} > need_q) begin
                mem_we    = 1'b1;
                mem_waddr = cand_idx_q;
                mem_wdata = '{addr: cand_addr_q + AW'(need_q),
                              size: SIZE_W'({1'b0, cand_size_q} - need_q)};
              end else begin
                valid_d[cand_idx_q] = 1'b0;
              end
            end else begin
              res_status_d = STATUS_MISS;
            end
          end
          OP_PLAIN: begin
            if (hit_found_q) begin
              res_status_d = STATUS_STORED;
            end else if (free_found_q) begin
              res_status_d        = STATUS_STORED;
              mem_we              = 1'b1;
              mem_waddr           = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
            end else begin
              res_status_d = STATUS_DROPPED;
            end
          end
          OP_MERGE: begin
            if (hit_found_q) begin
              valid_d[hit_idx_q] = 1'b0;
            end
            if (left_ok) begin
              valid_d[cand_idx_q] = 1'b0;
            end
            if (slot_found) begin
              res_status_d      = STATUS_STORED;
              mem_we            = 1'b1;
              mem_waddr         = slot_idx;
              mem_wdata         = '{addr: new_addr, size: new_size};
              valid_d[slot_idx] = 1'b1;
            end else begin
              res_status_d = STATUS_DROPPED;
            end
          end
          default: begin
            res_status_d = STATUS_DROPPED;
          end
        endcase
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = '{status: res_status_q, granted_address: res_addr_q};
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      merge_q      <= CFG_MERGE_RESET;
      page_log2_q  <= CFG_PAGE_RESET;
      rd_cnt_q     <= '0;
      cmp_vld_q    <= 1'b0;
      cand_found_q <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
      rd_cnt_q     <= rd_cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      cand_found_q <= cand_found_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MERGE_ON_RELEASE: merge_q     <= cfg_wdata_i[0];
          CFG_PAGE_LOG2:        page_log2_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_addr_q   <= req_addr_d;
    req_size_q   <= req_size_d;
    need_q       <= need_d;
    end_q        <= end_d;
    cmp_idx_q    <= cmp_idx_d;
    rd_valid_q   <= rd_valid_d;
    cand_idx_q   <= cand_idx_d;
    cand_addr_q  <= cand_addr_d;
    cand_size_q  <= cand_size_d;
    hit_idx_q    <= hit_idx_d;
    hit_size_q   <= hit_size_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ sv/bfc_checker.sv @@
module bfc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input bfc_pkg::out_item_t             out_item_o
);
  import bfc_pkg::*;

  // Only one item is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is still in work");

  // A fresh result appears only as the item in work completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in work");

  // Only a served allocation carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == STATUS_SERVED) ||
                    (out_item_o.granted_address == '0))
    else $error("address given with a result that was not served");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind best_fit_free_block_cache bfc_checker u_bfc_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bfc_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_W        = 48;

  // This covers one full item that needs the table after the last result
  // has been taken.
  localparam int SETTLE_CYCLES = 80;

  // A free span that the block handed out; the stimulus gives these back later
  // so that releases meet their old neighbors and coalesce.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } span_t;

  // Mirror of the free block table. Every accepted request item is applied to
  // this copy at once, and the result it must give is queued in order.
  class fit_scoreboard;
    bit              slot_used [TABLE_ENTRIES];
    bit [ADDR_W-1:0] slot_addr [TABLE_ENTRIES];
    bit [SIZE_W-1:0] slot_size [TABLE_ENTRIES];
    bit              merge_mode;
    bit [4:0]        page_shift;
    bit [SIZE_W-1:0] last_grant_size;
    out_item_t       awaited_results[$];
    int unsigned     error_count;

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
      end
      merge_mode  = CFG_MERGE_RESET;
      page_shift  = CFG_PAGE_RESET;
      error_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_MERGE_ON_RELEASE) begin
        merge_mode = data[0];
      end else begin
        page_shift = data;
      end
    endfunction

    function int first_free();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!slot_used[i]) return i;
      end
      return -1;
    endfunction

    function void store(int slot, bit [ADDR_W-1:0] addr, bit [SIZE_W-1:0] size);
      slot_used[slot] = 1'b1;
      slot_addr[slot] = addr;
      slot_size[slot] = size;
    endfunction

    function logic [STATUS_W-1:0] predict_alloc(bit [SIZE_W-1:0] size,
                                                output bit [ADDR_W-1:0] grant);
      bit [63:0] page;
      bit [63:0] need;
      int        best;
      grant = '0;
      best  = -1;
      if (size == 0) return STATUS_MISS;
      page = 64'd1 << page_shift;
      need = ((64'(size) + page - 64'd1) >> page_shift) << page_shift;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!slot_used[i] || 64'(slot_size[i]) < need) continue;
        if (best < 0 || slot_size[i] < slot_size[best] ||
            (slot_size[i] == slot_size[best] && slot_addr[i] < slot_addr[best])) begin
          best = i;
        end
      end
      if (best < 0) return STATUS_MISS;
      grant           = slot_addr[best];
      last_grant_size = need[SIZE_W-1:0];
      if (64'(slot_size[best]) > need) begin
        // The rest stays in the same slot, just past the granted part.
        slot_addr[best] = slot_addr[best] + need[ADDR_W-1:0];
        slot_size[best] = slot_size[best] - need[SIZE_W-1:0];
      end else begin
        slot_used[best] = 1'b0;
      end
      return STATUS_SERVED;
    endfunction

    function logic [STATUS_W-1:0] predict_plain(bit [SIZE_W-1:0] size, bit [ADDR_W-1:0] addr);
      int slot;
      if (size == 0 || 64'(size) < (64'd1 << page_shift)) return STATUS_DROPPED;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i] && slot_addr[i] == addr && slot_size[i] == size) return STATUS_STORED;
      end
      slot = first_free();
      if (slot < 0) return STATUS_DROPPED;
      store(slot, addr, size);
      return STATUS_STORED;
    endfunction

    function logic [STATUS_W-1:0] predict_merge(bit [SIZE_W-1:0] size, bit [ADDR_W-1:0] addr);
      bit [ADDR_W-1:0] tail;
      int              left;
      int              slot;
      left = -1;
      if (size == 0) return STATUS_DROPPED;
      tail = addr + ADDR_W'(size);
      // A neighbor joins only if the sum still fits the size field; ~size is
      // the largest size that can be added.
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i] && slot_addr[i] == tail && slot_size[i] <= ~size) begin
          slot_used[i] = 1'b0;
          size = size + slot_size[i];
          break;
        end
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!slot_used[i] || slot_addr[i] >= addr) continue;
        if (left < 0 || slot_addr[i] > slot_addr[left]) left = i;
      end
      if (left >= 0 && slot_addr[left] + ADDR_W'(slot_size[left]) == addr &&
          slot_size[left] <= ~size) begin
        slot_used[left] = 1'b0;
        addr = slot_addr[left];
        size = size + slot_size[left];
      end
      slot = first_free();
      if (slot < 0) return STATUS_DROPPED;
      store(slot, addr, size);
      return STATUS_STORED;
    endfunction

    function out_item_t take_request(in_item_t req);
      out_item_t       want;
      bit [ADDR_W-1:0] grant;
      grant = '0;
      if (req.mode == MODE_ALLOC) begin
        want.status = predict_alloc(req.block_size, grant);
      end else if (merge_mode) begin
        want.status = predict_merge(req.block_size, req.block_address);
      end else begin
        want.status = predict_plain(req.block_size, req.block_address);
      end
      want.granted_address = (want.status == STATUS_SERVED) ? grant : '0;
      awaited_results.push_back(want);
      return want;
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("result item with no request waiting: status %0d address %h",
               got.status, got.granted_address);
        error_count++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        error_count++;
      end
      if (got.granted_address !== want.granted_address) begin
        $error("granted_address: expected %h, actual %h",
               want.granted_address, got.granted_address);
        error_count++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  fit_scoreboard sb = new();

  // Spans granted by the block and not yet given back.
  span_t             lent_spans[$];
  logic [ADDR_W-1:0] region_base;
  int unsigned       burst_left;
  bit                sender_high;

  best_fit_free_block_cache #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDRESS_BITS (ADDR_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand_bits64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t mk(logic mode, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    in_item_t req;
    req.mode          = mode;
    req.block_size    = size;
    req.block_address = addr;
    return req;
  endfunction

  // Builds one random request item. The value of pick chooses the kind: below
  // 35 an allocate, below 70 the return of a granted span, below 85 a fresh
  // block in the current region, otherwise fully random noise. When nothing is
  // on loan a return turns into a fresh block.
  function automatic in_item_t random_request(int unsigned pick);
    in_item_t    req;
    logic [63:0] page;
    logic [63:0] raw;
    int unsigned idx;
    page = 64'd1 << sb.page_shift;
    raw  = rand_bits64();
    req  = mk(MODE_ALLOC, raw[SIZE_W-1:0], ADDR_W'(rand_bits64()));
    if (pick < 35) begin
      case ($urandom_range(0, 9))
        0:       req.block_size = raw[SIZE_W-1:0];
        1:       req.block_size = '0;
        default: req.block_size = SIZE_W'(64'($urandom_range(1, 4)) * page - (raw & (page - 1)));
      endcase
    end else if (pick < 70 && lent_spans.size() != 0) begin
      idx = $urandom_range(0, lent_spans.size() - 1);
      req = mk(MODE_RELEASE, lent_spans[idx].size, lent_spans[idx].addr);
      lent_spans.delete(idx);
    end else if (pick < 85) begin
      req.mode          = MODE_RELEASE;
      req.block_address = region_base + ADDR_W'(64'($urandom_range(0, 31)) * page);
      if ($urandom_range(0, 7) == 0) begin
        // Shorter than a page or exactly one page long.
        req.block_size = SIZE_W'(64'd1 + (raw & (page - 1)));
      end else begin
        req.block_size = SIZE_W'(64'($urandom_range(1, 4)) * page);
      end
    end else begin
      req.mode = raw[63];
    end
    return req;
  endfunction

  // Presents one item and holds it until the block takes it. Items go out in
  // bursts; when a burst ends, valid drops for a random gap so that idle
  // cycles land on every phase of the table scan.
  task automatic push_item(input in_item_t req);
    out_item_t   want;
    int unsigned gap;
    in_item_i   <= req;
    in_valid_i  <= 1'b1;
    sender_high = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    want = sb.take_request(req);
    if (req.mode == MODE_ALLOC && want.status == STATUS_SERVED) begin
      lent_spans.push_back('{want.granted_address, sb.last_grant_size});
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i  <= 1'b0;
      sender_high = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
  endtask

  // Stops sending and waits until every result has come back, which leaves
  // the block idle and ready for register writes.
  task automatic drain_table();
    if (sender_high) begin
      in_valid_i  <= 1'b0;
      sender_high = 1'b0;
      @(posedge clk_i);
    end
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both registers back to back, merge mode first.
  task automatic program_regs(input logic merge, input logic [CFG_DATA_W-1:0] page_log2);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MERGE_ON_RELEASE;
    cfg_wdata_i <= CFG_DATA_W'(merge);
    @(posedge clk_i);
    sb.set_reg(CFG_MERGE_ON_RELEASE, CFG_DATA_W'(merge));
    cfg_index_i <= CFG_PAGE_LOG2;
    cfg_wdata_i <= page_log2;
    @(posedge clk_i);
    sb.set_reg(CFG_PAGE_LOG2, page_log2);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The receiver switches among random stall modes: no stall at all,
  // scattered random stalls, or long stretches of stall.
  initial begin : result_sink
    int unsigned mode_left;
    int unsigned mode_kind;
    int unsigned run_left;
    bit          run_stall;
    out_stall_i = 1'b0;
    mode_left   = 0;
    mode_kind   = 0;
    run_left    = 0;
    run_stall   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.match_result(out_item_o);
      if (mode_left == 0) begin
        mode_kind = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (mode_kind)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        default: begin
          if (run_left == 0) begin
            run_stall = !run_stall;
            run_left  = run_stall ? $urandom_range(1, 20) : $urandom_range(1, 10);
          end
          run_left--;
          out_stall_i <= run_stall;
        end
      endcase
    end
  end

  initial begin : stimulus
    logic                  merge;
    logic [CFG_DATA_W-1:0] shift;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_MERGE_ON_RELEASE;
    cfg_wdata_i = '0;
    sender_high = 1'b0;
    burst_left  = 1;
    region_base = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, merge mode with 4 KiB pages, starting from an empty table.
    program_regs(1'b1, 5'd12);
    push_item(mk(MODE_ALLOC, 41'd0, 48'h0));               // zero-size allocate
    push_item(mk(MODE_ALLOC, 41'd1, 48'h0));               // empty table misses
    push_item(mk(MODE_RELEASE, 41'h3000, 48'h1000));
    push_item(mk(MODE_RELEASE, 41'h1000, 48'h4000));       // joins its left neighbor
    push_item(mk(MODE_RELEASE, 41'h1000, 48'h0));          // joins its right neighbor
    push_item(mk(MODE_RELEASE, 41'd0, 48'h8000));          // zero-size release
    push_item(mk(MODE_ALLOC, 41'd1, 48'h0));               // rounds up to one page
    push_item(mk(MODE_ALLOC, 41'h1001, '1));               // address field is ignored
    push_item(mk(MODE_ALLOC, '1, 48'h0));                  // rounds past the size field
    push_item(mk(MODE_RELEASE, 41'h1800, 48'hFFFF_FFFF_F000));
    push_item(mk(MODE_ALLOC, 41'h1000, 48'h0));            // remainder wraps to address 0
    push_item(mk(MODE_RELEASE, 41'h1000, 48'hFFFF_FFFF_F000)); // end wraps onto that rest
    push_item(mk(MODE_RELEASE, '1, 48'h5000));             // sum would overflow, kept apart
    push_item(mk(MODE_ALLOC, 41'h1FF_FFFF_F000, 48'h0));
    push_item(mk(MODE_RELEASE, 41'd1, '1));
    push_item(mk(MODE_ALLOC, 41'h1000, '1));

    // Same table without merging.
    drain_table();
    program_regs(1'b0, 5'd12);
    push_item(mk(MODE_RELEASE, 41'h800, 48'h10_0000));     // shorter than a page
    push_item(mk(MODE_RELEASE, 41'h1000, 48'h10_0000));
    push_item(mk(MODE_RELEASE, 41'h1000, 48'h10_0000));    // identical block, no second entry
    push_item(mk(MODE_RELEASE, 41'h1000, 48'h30_0000));
    push_item(mk(MODE_RELEASE, 41'h1000, 48'h20_0000));
    push_item(mk(MODE_ALLOC, 41'h1000, 48'h0));            // tie goes to the lowest address
    push_item(mk(MODE_ALLOC, 41'h1000, 48'h0));

    // Fill the table with small separate blocks until releases are dropped.
    drain_table();
    program_regs(1'b0, 5'd3);
    region_base = ADDR_W'(rand_bits64() & ~64'd7);
    for (int i = 0; i < 70; i++) begin
      push_item(mk(MODE_RELEASE, 41'd8, region_base + ADDR_W'(i * 32)));
    end
    push_item(mk(MODE_RELEASE, 41'd8, region_base));
    drain_table();
    program_regs(1'b1, 5'd3);
    push_item(mk(MODE_RELEASE, 41'd8, region_base + ADDR_W'(80 * 32))); // full, no neighbor
    push_item(mk(MODE_RELEASE, 41'd24, region_base + ADDR_W'(8)));      // bridges two blocks
    repeat (30) push_item(mk(MODE_ALLOC, SIZE_W'($urandom_range(1, 40)),
                             ADDR_W'(rand_bits64())));

    // Random phases over several register settings, the extremes first.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin merge = 1'b1; shift = 5'd0;  end
        1: begin merge = 1'b0; shift = 5'd31; end
        2: begin merge = 1'b1; shift = 5'd31; end
        3: begin merge = 1'b0; shift = 5'd0;  end
        4: begin merge = 1'b1; shift = 5'd5;  end
        5: begin merge = 1'b0; shift = 5'd12; end
        default: begin
          merge = 1'($urandom_range(0, 1));
          shift = CFG_DATA_W'($urandom_range(0, 31));
        end
      endcase
      drain_table();
      program_regs(merge, shift);
      region_base = ADDR_W'(rand_bits64() & ~((64'd1 << shift) - 64'd1));
      repeat (4) push_item(random_request(75));
      repeat (30) push_item(random_request($urandom_range(0, 99)));
    end

    drain_table();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
